### sv/cdzp_pkg.sv
// Shared constants, types and helper functions of the zero-padded 2D convolution stream.
package cdzp_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MAX_KERNEL     = 5;
  localparam int COEF_FRAC_BITS = 14;

  localparam int TAPS    = MAX_KERNEL * MAX_KERNEL;
  localparam int LANES   = MAX_KERNEL - 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = 11;
  localparam int ROW_W   = 13;
  localparam int OROW_W  = 12;
  localparam int KSIZE_W = 3;
  localparam int RAD_W   = 2;
  localparam int CIDX_W  = 5;
  localparam int DATA_W  = 16;
  localparam int RES_W   = 24;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int RSUM_W  = PROD_W + 3;
  localparam int SUM_W   = PROD_W + 5;
  localparam int CNT_W   = 2;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;
  localparam int CFG_W   = 13;
  localparam int CIDXR_W = 2;

  localparam logic [1:0] MODE_COEF  = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_DRAIN = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [CIDXR_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CIDXR_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CIDXR_W-1:0] REG_KSIZE  = 2'd2;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef sample_t [TAPS-1:0] window_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [ROW_W-1:0]    height;
    logic [KSIZE_W-1:0]  ksize;
    logic [RAD_W-1:0]    radius;
  } geom_t;

  typedef struct packed {
    logic               is_coef;
    logic [CIDX_W-1:0]  coef_index;
    sample_t            coef_value;
    window_t            win;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COL_W-1:0]   first;
    logic [CNT_W-1:0]   count;
  } job_t;

  function automatic logic [KSIZE_W-1:0] eff_kernel(input logic [KSIZE_W-1:0] k);
    logic [KSIZE_W-1:0] v;
    v = k;
    if (v > KSIZE_W'(MAX_KERNEL)) v = KSIZE_W'(MAX_KERNEL);
    if (v == '0) v = KSIZE_W'(1);
    if (!v[0]) v = v - KSIZE_W'(1);
    return v;
  endfunction

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] v;
    v = w;
    if (v == '0) v = WIDTH_W'(1);
    if (v > WIDTH_W'(MAX_WIDTH)) v = WIDTH_W'(MAX_WIDTH);
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] h);
    logic [ROW_W-1:0] v;
    v = h;
    if (v == '0) v = ROW_W'(1);
    if (v > ROW_W'(MAX_HEIGHT)) v = ROW_W'(MAX_HEIGHT);
    return v;
  endfunction

endpackage

### sv/cdzp_if.sv
// Valid/ready channel interfaces for input items and convolution results.
interface cdzp_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [15:0]           pixel_value;
  logic [4:0]                   coef_index;
  logic signed [15:0]           coef_value;
  modport source (output valid, mode, pixel_value, coef_index, coef_value, input ready);
  modport sink (input valid, mode, pixel_value, coef_index, coef_value, output ready);
endinterface

interface cdzp_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [23:0]           result_value;
  logic [11:0]                  out_row;
  logic [9:0]                   out_col;
  logic                         last_of_run;
  logic                         frame_done;
  modport source (output valid, result_value, out_row, out_col, last_of_run, frame_done,
                  input ready);
  modport sink (input valid, result_value, out_row, out_col, last_of_run, frame_done,
                output ready);
endinterface

### sv/cdzp_front.sv
// Front end: accepts items, tracks the raster position, keeps line store and window.
module cdzp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  cdzp_pkg::geom_t               geom,
  input  logic                          restart,
  input  logic [cdzp_pkg::QCNT_W-1:0]   free,
  cdzp_in_if.sink                       pixels,
  output logic                          push,
  output cdzp_pkg::job_t                job
);

  localparam int LW = cdzp_pkg::DATA_W * cdzp_pkg::LANES;

  logic [LW-1:0] line_mem [cdzp_pkg::MAX_WIDTH];
  logic [LW-1:0] rd_word;
  logic [LW-1:0] byp_word;
  logic          byp_hit;
  logic [LW-1:0] word;
  logic [LW-1:0] wr_word;
  logic          wr_en;

  logic [cdzp_pkg::ROW_W-1:0] row;
  logic [cdzp_pkg::COL_W-1:0] col;
  logic [cdzp_pkg::ROW_W-1:0] row_next;
  logic [cdzp_pkg::COL_W-1:0] col_next;
  logic [cdzp_pkg::ROW_W-1:0] cur_row;
  logic [cdzp_pkg::COL_W-1:0] cur_col;
  logic [cdzp_pkg::ROW_W:0]   row_lim;
  logic [cdzp_pkg::ROW_W:0]   row_inc;
  logic [cdzp_pkg::WIDTH_W-1:0] col_inc;

  logic acc;
  logic is_pos;

  logic                          f1_valid;
  logic                          f1_coef;
  logic [cdzp_pkg::ROW_W-1:0]    f1_row;
  logic [cdzp_pkg::COL_W-1:0]    f1_col;
  cdzp_pkg::sample_t             f1_pix;
  logic [cdzp_pkg::CIDX_W-1:0]   f1_cidx;
  cdzp_pkg::sample_t             f1_cval;

  cdzp_pkg::window_t win;
  cdzp_pkg::window_t win_next;
  cdzp_pkg::sample_t lane [cdzp_pkg::MAX_KERNEL];
  cdzp_pkg::sample_t newcol [cdzp_pkg::MAX_KERNEL];

  logic                          row_ok;
  logic                          at_end;
  logic                          col_ge;
  logic [cdzp_pkg::COL_W-1:0]    first_v;
  logic [cdzp_pkg::CNT_W-1:0]    count_v;
  int                            kk;

  assign pixels.ready = free > cdzp_pkg::QCNT_W'(f1_valid);
  assign acc = pixels.valid && pixels.ready;
  assign is_pos = acc && (pixels.mode == cdzp_pkg::MODE_PIXEL ||
                          pixels.mode == cdzp_pkg::MODE_DRAIN);

  always_comb begin
    row_lim = (cdzp_pkg::ROW_W+1)'(geom.height) - (cdzp_pkg::ROW_W+1)'(1)
            + (cdzp_pkg::ROW_W+1)'(geom.radius);
    cur_col = ({1'b0, col} >= geom.width) ? '0 : col;
    cur_row = ({1'b0, row} > row_lim) ? '0 : row;
    col_inc = cdzp_pkg::WIDTH_W'(cur_col) + cdzp_pkg::WIDTH_W'(1);
    row_inc = (cdzp_pkg::ROW_W+1)'(cur_row) + (cdzp_pkg::ROW_W+1)'(1);
    if (col_inc >= geom.width) begin
      col_next = '0;
      row_next = (row_inc > row_lim) ? '0 : row_inc[cdzp_pkg::ROW_W-1:0];
    end else begin
      col_next = col_inc[cdzp_pkg::COL_W-1:0];
      row_next = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row <= '0;
      col <= '0;
    end else if (is_pos) begin
      row <= row_next;
      col <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      f1_valid <= acc && pixels.mode != cdzp_pkg::MODE_NONE;
      byp_hit  <= is_pos && wr_en && f1_col == cur_col;
    end
    byp_word <= wr_word;
    f1_coef  <= pixels.mode == cdzp_pkg::MODE_COEF;
    f1_row   <= cur_row;
    f1_col   <= cur_col;
    f1_pix   <= (pixels.mode == cdzp_pkg::MODE_PIXEL && {1'b0, cur_row} < {1'b0, geom.height})
              ? pixels.pixel_value : '0;
    f1_cidx  <= pixels.coef_index;
    f1_cval  <= pixels.coef_value;
  end

  always_ff @(posedge clk) begin
    if (is_pos) rd_word <= line_mem[cur_col];
    if (wr_en) line_mem[f1_col] <= wr_word;
  end

  always_comb begin
    kk = int'(geom.ksize);
    word = byp_hit ? byp_word : rd_word;
    for (int ii = 0; ii < cdzp_pkg::MAX_KERNEL; ii++) begin
      lane[ii] = (ii < cdzp_pkg::LANES) ? word[ii*cdzp_pkg::DATA_W +: cdzp_pkg::DATA_W] : '0;
    end
    for (int ii = 0; ii < cdzp_pkg::MAX_KERNEL; ii++) begin
      if (ii == kk - 1) newcol[ii] = f1_pix;
      else if (ii < kk - 1) newcol[ii] = lane[ii];
      else newcol[ii] = '0;
    end
    wr_word = word;
    for (int ii = 0; ii < cdzp_pkg::LANES; ii++) begin
      if (ii + 1 < kk - 1) wr_word[ii*cdzp_pkg::DATA_W +: cdzp_pkg::DATA_W] = lane[ii+1];
      else if (ii == kk - 2) wr_word[ii*cdzp_pkg::DATA_W +: cdzp_pkg::DATA_W] = f1_pix;
    end
    wr_en = f1_valid && !f1_coef && kk >= 2;
    win_next = win;
    if (f1_valid && !f1_coef) begin
      for (int ii = 0; ii < cdzp_pkg::MAX_KERNEL; ii++) begin
        for (int jj = 0; jj < cdzp_pkg::MAX_KERNEL; jj++) begin
          if (ii < kk) begin
            if (jj < kk - 1) begin
              win_next[ii*cdzp_pkg::MAX_KERNEL+jj] = win[ii*cdzp_pkg::MAX_KERNEL+jj+1];
            end else if (jj == kk - 1) begin
              win_next[ii*cdzp_pkg::MAX_KERNEL+jj] = newcol[ii];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) win <= '0;
    else win <= win_next;
  end

  always_comb begin
    row_ok  = f1_row >= cdzp_pkg::ROW_W'(geom.radius);
    at_end  = cdzp_pkg::WIDTH_W'(f1_col) == geom.width - cdzp_pkg::WIDTH_W'(1);
    col_ge  = f1_col >= cdzp_pkg::COL_W'(geom.radius);
    first_v = col_ge ? f1_col - cdzp_pkg::COL_W'(geom.radius) : '0;
    if (!row_ok) count_v = '0;
    else if (at_end) count_v = cdzp_pkg::CNT_W'(geom.width - cdzp_pkg::WIDTH_W'(first_v));
    else if (col_ge) count_v = cdzp_pkg::CNT_W'(1);
    else count_v = '0;
  end

  assign push = f1_valid && (f1_coef || count_v != '0);

  always_comb begin
    job.is_coef    = f1_coef;
    job.coef_index = f1_cidx;
    job.coef_value = f1_cval;
    job.win        = win_next;
    job.row        = f1_row;
    job.col        = f1_col;
    job.first      = first_v;
    job.count      = count_v;
  end

endmodule

### sv/cdzp_queue.sv
// Short job queue between the front end and the arithmetic back end.
module cdzp_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  cdzp_pkg::job_t               push_job,
  input  logic                         pop,
  output logic                         head_valid,
  output cdzp_pkg::job_t               head,
  output logic [cdzp_pkg::QCNT_W-1:0]  free
);

  cdzp_pkg::job_t entries [cdzp_pkg::QDEPTH];
  logic [cdzp_pkg::QPTR_W-1:0] wr_ptr;
  logic [cdzp_pkg::QPTR_W-1:0] rd_ptr;
  logic [cdzp_pkg::QCNT_W-1:0] fill;

  assign head_valid = fill != '0;
  assign head = entries[rd_ptr];
  assign free = cdzp_pkg::QCNT_W'(cdzp_pkg::QDEPTH) - fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + cdzp_pkg::QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + cdzp_pkg::QPTR_W'(1);
      fill <= fill + cdzp_pkg::QCNT_W'(push) - cdzp_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

### sv/cdzp_back.sv
// Back end: coefficient table, masked tap products, adder tree and saturation.
module cdzp_back (
  input  logic             clk,
  input  logic             rst,
  input  cdzp_pkg::geom_t  geom,
  input  logic             head_valid,
  input  cdzp_pkg::job_t   head,
  output logic             pop,
  cdzp_out_if.source       results
);

  localparam int MK = cdzp_pkg::MAX_KERNEL;

  cdzp_pkg::sample_t coef_tab [cdzp_pkg::TAPS];
  logic [cdzp_pkg::CNT_W-1:0] n;
  logic adv;
  logic produce;
  logic last_v;

  logic [cdzp_pkg::COL_W-1:0] c0;
  int kk;
  int rr;
  int dd;

  cdzp_pkg::sample_t op_pix  [cdzp_pkg::TAPS];
  cdzp_pkg::sample_t op_coef [cdzp_pkg::TAPS];

  logic                         a1_valid;
  cdzp_pkg::sample_t            a1_pix  [cdzp_pkg::TAPS];
  cdzp_pkg::sample_t            a1_coef [cdzp_pkg::TAPS];
  logic [cdzp_pkg::OROW_W-1:0]  a1_row;
  logic [cdzp_pkg::COL_W-1:0]   a1_col;
  logic                         a1_last;
  logic                         a1_done;

  logic                             a2_valid;
  logic signed [cdzp_pkg::PROD_W-1:0] a2_prod [cdzp_pkg::TAPS];
  logic [cdzp_pkg::OROW_W-1:0]      a2_row;
  logic [cdzp_pkg::COL_W-1:0]       a2_col;
  logic                             a2_last;
  logic                             a2_done;

  logic                             a3_valid;
  logic signed [cdzp_pkg::RSUM_W-1:0] a3_rsum [MK];
  logic [cdzp_pkg::OROW_W-1:0]      a3_row;
  logic [cdzp_pkg::COL_W-1:0]       a3_col;
  logic                             a3_last;
  logic                             a3_done;

  logic signed [cdzp_pkg::SUM_W-1:0] total;
  logic signed [cdzp_pkg::SUM_W-1:0] scaled;
  logic signed [cdzp_pkg::RES_W-1:0] sat;

  assign adv     = !(results.valid && !results.ready);
  assign produce = head_valid && !head.is_coef;
  assign last_v  = n == head.count - cdzp_pkg::CNT_W'(1);
  assign pop     = adv && head_valid && (head.is_coef || last_v);
  assign c0      = head.first + cdzp_pkg::COL_W'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (adv && produce) begin
      n <= last_v ? '0 : n + cdzp_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < cdzp_pkg::TAPS; t++) coef_tab[t] <= '0;
    end else if (adv && head_valid && head.is_coef &&
                 head.coef_index < cdzp_pkg::CIDX_W'(cdzp_pkg::TAPS)) begin
      coef_tab[head.coef_index] <= head.coef_value;
    end
  end

  always_comb begin
    int rowpos;
    int colpos;
    int widx;
    logic ok;
    kk = int'(geom.ksize);
    rr = int'(geom.radius);
    dd = int'(c0) + rr - int'(head.col);
    for (int ii = 0; ii < MK; ii++) begin
      for (int jj = 0; jj < MK; jj++) begin
        rowpos = int'(head.row) - 2 * rr + ii;
        colpos = int'(c0) - rr + jj;
        widx   = dd + jj;
        ok = ii < kk && jj < kk && rowpos >= 0 && rowpos < int'(geom.height) &&
             colpos >= 0 && colpos < int'(geom.width) && widx >= 0 && widx < kk;
        op_pix[ii*MK+jj]  = '0;
        op_coef[ii*MK+jj] = '0;
        if (ok) begin
          op_pix[ii*MK+jj] = head.win[ii*MK+widx];
          case (geom.ksize)
            3'd5:    op_coef[ii*MK+jj] = coef_tab[ii*5+jj];
            3'd3:    op_coef[ii*MK+jj] = coef_tab[ii*3+jj];
            default: op_coef[ii*MK+jj] = coef_tab[0];
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_valid <= 1'b0;
      a2_valid <= 1'b0;
      a3_valid <= 1'b0;
      results.valid <= 1'b0;
    end else if (adv) begin
      a1_valid <= produce;
      a2_valid <= a1_valid;
      a3_valid <= a2_valid;
      results.valid <= a3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_pix  <= op_pix;
      a1_coef <= op_coef;
      a1_row  <= cdzp_pkg::OROW_W'(head.row - cdzp_pkg::ROW_W'(geom.radius));
      a1_col  <= c0;
      a1_last <= last_v;
      a1_done <= (head.row - cdzp_pkg::ROW_W'(geom.radius)) ==
                   (geom.height - cdzp_pkg::ROW_W'(1)) &&
                 cdzp_pkg::WIDTH_W'(c0) == geom.width - cdzp_pkg::WIDTH_W'(1);

      for (int t = 0; t < cdzp_pkg::TAPS; t++) begin
        a2_prod[t] <= a1_pix[t] * a1_coef[t];
      end
      a2_row  <= a1_row;
      a2_col  <= a1_col;
      a2_last <= a1_last;
      a2_done <= a1_done;

      for (int ii = 0; ii < MK; ii++) begin
        a3_rsum[ii] <= cdzp_pkg::RSUM_W'(a2_prod[ii*MK])   + cdzp_pkg::RSUM_W'(a2_prod[ii*MK+1])
                     + cdzp_pkg::RSUM_W'(a2_prod[ii*MK+2]) + cdzp_pkg::RSUM_W'(a2_prod[ii*MK+3])
                     + cdzp_pkg::RSUM_W'(a2_prod[ii*MK+4]);
      end
      a3_row  <= a2_row;
      a3_col  <= a2_col;
      a3_last <= a2_last;
      a3_done <= a2_done;

      results.result_value <= sat;
      results.out_row      <= a3_row;
      results.out_col      <= a3_col;
      results.last_of_run  <= a3_last;
      results.frame_done   <= a3_done;
    end
  end

  always_comb begin
    total = '0;
    for (int ii = 0; ii < MK; ii++) total = total + cdzp_pkg::SUM_W'(a3_rsum[ii]);
    scaled = total >>> cdzp_pkg::COEF_FRAC_BITS;
    if (scaled > cdzp_pkg::SUM_W'(8388607)) sat = 24'sh7FFFFF;
    else if (scaled < -cdzp_pkg::SUM_W'(8388608)) sat = 24'sh800000;
    else sat = scaled[cdzp_pkg::RES_W-1:0];
  end

endmodule

### sv/conv2d_zero_padded_stream.sv
// Top level of the zero-padded KxK 2D convolution stream with its configuration registers.
// The block takes one transaction per clock while the queue has room: pixels, drain
// positions and coefficient writes all enter at that rate, and the back end delivers one
// result per clock while the output is ready. A position at the end of a row causes up to
// R+1 results; the four-entry job queue absorbs this, so input stalls only when the queue
// lacks room for a new item besides the one in flight. The front end registers the item
// and its line store read at the accepting edge (the line store being one 1024-word memory
// read and written once per position for K of at least 3); the window update and the queue
// write share the next edge, and the operand, multiply, row-sum and output stages follow,
// each registered. Write the configuration only while the block is idle; a write to the
// width, height or kernel-size register restarts the frame.
module conv2d_zero_padded_stream (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cdzp_pkg::CIDXR_W-1:0]  cfg_index,
  input  logic [cdzp_pkg::CFG_W-1:0]    cfg_data,
  cdzp_in_if.sink                       pixels,
  cdzp_out_if.source                    results
);

  logic [cdzp_pkg::WIDTH_W-1:0] frame_width;
  logic [cdzp_pkg::ROW_W-1:0]   frame_height;
  logic [cdzp_pkg::KSIZE_W-1:0] kernel_size;
  cdzp_pkg::geom_t              geom;
  logic                         restart;

  logic                         push;
  cdzp_pkg::job_t               push_job;
  logic                         pop;
  logic                         head_valid;
  cdzp_pkg::job_t               head;
  logic [cdzp_pkg::QCNT_W-1:0]  free;

  assign restart = cfg_write && cfg_index <= cdzp_pkg::REG_KSIZE;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= cdzp_pkg::WIDTH_W'(640);
      frame_height <= cdzp_pkg::ROW_W'(480);
      kernel_size  <= cdzp_pkg::KSIZE_W'(3);
    end else if (cfg_write) begin
      case (cfg_index)
        cdzp_pkg::REG_WIDTH:  frame_width  <= cfg_data[cdzp_pkg::WIDTH_W-1:0];
        cdzp_pkg::REG_HEIGHT: frame_height <= cfg_data[cdzp_pkg::ROW_W-1:0];
        cdzp_pkg::REG_KSIZE:  kernel_size  <= cfg_data[cdzp_pkg::KSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.width  = cdzp_pkg::eff_width(frame_width);
    geom.height = cdzp_pkg::eff_height(frame_height);
    geom.ksize  = cdzp_pkg::eff_kernel(kernel_size);
    geom.radius = geom.ksize[cdzp_pkg::RAD_W:1];
  end

  cdzp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .restart (restart),
    .free    (free),
    .pixels  (pixels),
    .push    (push),
    .job     (push_job)
  );

  cdzp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .free       (free)
  );

  cdzp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );

endmodule
